@@ rtl/fbc_pkg.sv @@
// Package for the frustum box cull block: widths, plane layout, verdict codes.
// No dependencies; every other file of the block depends on it.
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W     = 16;
  localparam int PROD_W      = 2 * COORD_W;
  // Three products plus the offset scaled by 2^14, with headroom for the sum.
  localparam int DIST_W      = PROD_W + 3;
  localparam int OFFSET_SH   = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 4 * COORD_W;
  localparam int OCC_W       = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  // Register packing: offset in the top 16 bits, then normal z, y, x.
  typedef struct packed {
    logic signed [COORD_W-1:0] offset;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } plane_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_NEAR   = 3'd0,
    REG_PLANE_FAR    = 3'd1,
    REG_PLANE_LEFT   = 3'd2,
    REG_PLANE_RIGHT  = 3'd3,
    REG_PLANE_TOP    = 3'd4,
    REG_PLANE_BOTTOM = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_INTERSECT = 2'd1,
    VERDICT_OUTSIDE   = 2'd2
  } verdict_t;

endpackage

@@ rtl/fbc_if.sv @@
// Valid/ready channel interfaces for box requests and verdict results.
// Depends on fbc_pkg.
interface fbc_in_if;
  logic            valid;
  logic            ready;
  fbc_pkg::coord_t box_min_x;
  fbc_pkg::coord_t box_min_y;
  fbc_pkg::coord_t box_min_z;
  fbc_pkg::coord_t box_max_x;
  fbc_pkg::coord_t box_max_y;
  fbc_pkg::coord_t box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface fbc_out_if;
  logic              valid;
  logic              ready;
  fbc_pkg::verdict_t verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

@@ rtl/frustum_box_cull.sv @@
// Register stages: box, product, sign and output, the box stage loading at the
// request acceptance edge. Throughput: one box per cycle, set by the fully
// parallel 36-multiplier product stage; a stall holds each occupied stage and
// lets empty stages fill. Reset (rst_n, synchronous, active low) clears all stage
// valid bits and zeroes the six plane registers, so every box classifies as inside.
// Depends on fbc_pkg and fbc_if.
module frustum_box_cull (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fbc_in_if.sink                         in_box,
  fbc_out_if.source                      out_res
);
  import fbc_pkg::*;

  // plane registers
  plane_t plane_r [PLANE_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane_r[p] <= '0;
      end
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(PLANE_COUNT))) begin
      plane_r[cfg_idx] <= plane_t'(cfg_wdata);
    end
  end

  // stage valid bits and load enables
  logic bx_v_r, pr_v_r, sg_v_r, out_v_r;
  logic ld_bx, ld_pr, ld_sg, ld_out;

  assign ld_out = !out_v_r || out_res.ready;
  assign ld_sg  = !sg_v_r  || ld_out;
  assign ld_pr  = !pr_v_r  || ld_sg;
  assign ld_bx  = !bx_v_r  || ld_pr;

  assign in_box.ready = ld_bx;
  assign out_res.valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_v_r  <= 1'b0;
      pr_v_r  <= 1'b0;
      sg_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld_bx)  bx_v_r  <= in_box.valid;
      if (ld_pr)  pr_v_r  <= bx_v_r;
      if (ld_sg)  sg_v_r  <= pr_v_r;
      if (ld_out) out_v_r <= sg_v_r;
    end
  end

  // stage 1: capture the box request
  coord_t lo_r [3];
  coord_t hi_r [3];

  always_ff @(posedge clk) begin
    if (ld_bx) begin
      lo_r[0] <= in_box.box_min_x;
      lo_r[1] <= in_box.box_min_y;
      lo_r[2] <= in_box.box_min_z;
      hi_r[0] <= in_box.box_max_x;
      hi_r[1] <= in_box.box_max_y;
      hi_r[2] <= in_box.box_max_z;
    end
  end

  // stage 2: pick positive/negative corners per plane and multiply
  coord_t norm  [PLANE_COUNT][3];
  prod_t  pprod_nxt [PLANE_COUNT][3];
  prod_t  nprod_nxt [PLANE_COUNT][3];
  prod_t  pprod_r   [PLANE_COUNT][3];
  prod_t  nprod_r   [PLANE_COUNT][3];

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      norm[p][0] = plane_r[p].nx;
      norm[p][1] = plane_r[p].ny;
      norm[p][2] = plane_r[p].nz;
      for (int a = 0; a < 3; a++) begin
        // zero normal counts as non-negative: positive corner takes the max
        if (!norm[p][a][COORD_W-1]) begin
          pprod_nxt[p][a] = norm[p][a] * hi_r[a];
          nprod_nxt[p][a] = norm[p][a] * lo_r[a];
        end else begin
          pprod_nxt[p][a] = norm[p][a] * lo_r[a];
          nprod_nxt[p][a] = norm[p][a] * hi_r[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_pr) begin
      pprod_r <= pprod_nxt;
      nprod_r <= nprod_nxt;
    end
  end

  // stage 3: sum products with the scaled offset and keep the signs
  dist_t                  pdist, ndist, offs;
  logic [PLANE_COUNT-1:0] psign_nxt, nsign_nxt;
  logic [PLANE_COUNT-1:0] psign_r, nsign_r;

  always_comb begin
    psign_nxt = '0;
    nsign_nxt = '0;
    pdist = '0;
    ndist = '0;
    offs  = '0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      offs  = DIST_W'(plane_r[p].offset) <<< OFFSET_SH;
      pdist = DIST_W'(pprod_r[p][0]) + DIST_W'(pprod_r[p][1])
            + DIST_W'(pprod_r[p][2]) + offs;
      ndist = DIST_W'(nprod_r[p][0]) + DIST_W'(nprod_r[p][1])
            + DIST_W'(nprod_r[p][2]) + offs;
      psign_nxt[p] = pdist[DIST_W-1];
      nsign_nxt[p] = ndist[DIST_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_sg) begin
      psign_r <= psign_nxt;
      nsign_r <= nsign_nxt;
    end
  end

  // stage 4: reduce the signs to a verdict
  verdict_t verdict_nxt, verdict_r;

  always_comb begin
    if (|psign_r) begin
      verdict_nxt = VERDICT_OUTSIDE;
    end else if (|nsign_r) begin
      verdict_nxt = VERDICT_INTERSECT;
    end else begin
      verdict_nxt = VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_res.verdict = verdict_r;

endmodule

@@ rtl/fbc_checker.sv @@
// Port-level checker for frustum_box_cull, bound to the top level below.
// Depends on fbc_pkg.
module fbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_verdict
);
  import fbc_pkg::*;

  // track requests in flight: accepted but not yet delivered
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("result dropped or changed while stalled");

  // never emit the unused code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_INSIDE) ||
                  (out_verdict == VERDICT_INTERSECT) ||
                  (out_verdict == VERDICT_OUTSIDE))
    else $error("illegal verdict code");

  // no result without a pending request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result without a matching request");

  // at most one request per pipeline stage
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(4))
    else $error("more requests in flight than stages");

  // reset empties the output stage
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_box.valid),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_verdict (out_res.verdict)
);

@@ tb/tb.sv @@
// Self-checking bench for frustum_box_cull: drives boxes on the request channel,
// predicts each verdict from a shadow copy of the six plane registers and checks results.
// Depends on fbc_pkg, the fbc_in_if/fbc_out_if interfaces and the frustum_box_cull RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  localparam int LATENCY     = 4;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_BOXES = 115;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef enum {
    SET_SLAB,
    SET_RANDOM,
    SET_MOST_NEG,
    SET_MOST_POS,
    SET_ALL_ONES,
    SET_CLEARED
  } plane_set_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();

  frustum_box_cull i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_box    (in_ch),
    .out_res   (out_ch)
  );

  plane_t   plane_shadow[PLANE_COUNT];
  box_t     box_queue[$];
  verdict_t pending_verdicts[$];
  box_t     next_box;
  verdict_t want_verdict;
  bit       steady_flow;
  int       mismatch_count;
  int       boxes_accepted;
  int       verdicts_checked;
  int       verdict_seen[3];
  int       settings_used;
  int       quiet_cycles;

  plane_set_t schedule[12] = '{SET_SLAB, SET_RANDOM, SET_MOST_NEG, SET_SLAB, SET_MOST_POS,
                               SET_SLAB, SET_ALL_ONES, SET_RANDOM, SET_SLAB, SET_CLEARED,
                               SET_SLAB, SET_RANDOM};
  // axis and direction of each slab plane: near/far on z, left/right on x, top/bottom on y
  int slab_axis[PLANE_COUNT] = '{2, 2, 0, 0, 1, 1};
  bit slab_flip[PLANE_COUNT] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.min_x = coord_t'(lx);
    b.min_y = coord_t'(ly);
    b.min_z = coord_t'(lz);
    b.max_x = coord_t'(hx);
    b.max_y = coord_t'(hy);
    b.max_z = coord_t'(hz);
    return b;
  endfunction

  function automatic plane_t mk_plane(int nx, int ny, int nz, int off);
    plane_t p;
    p.nx     = coord_t'(nx);
    p.ny     = coord_t'(ny);
    p.nz     = coord_t'(nz);
    p.offset = coord_t'(off);
    return p;
  endfunction

  // Exact Q.22 sign test of the positive and negative corners against every plane.
  function automatic verdict_t classify_box(box_t b);
    coord_t  lo[3];
    coord_t  hi[3];
    coord_t  n[3];
    longint  d_pos;
    longint  d_neg;
    bit      outside;
    bit      crossing;
    lo = '{b.min_x, b.min_y, b.min_z};
    hi = '{b.max_x, b.max_y, b.max_z};
    outside  = 1'b0;
    crossing = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      n     = '{plane_shadow[i].nx, plane_shadow[i].ny, plane_shadow[i].nz};
      d_pos = longint'(plane_shadow[i].offset) * 64'sd16384;
      d_neg = d_pos;
      for (int a = 0; a < 3; a++) begin
        // a zero component counts as non-negative
        if (n[a] >= 0) begin
          d_pos += longint'(n[a]) * longint'(hi[a]);
          d_neg += longint'(n[a]) * longint'(lo[a]);
        end else begin
          d_pos += longint'(n[a]) * longint'(lo[a]);
          d_neg += longint'(n[a]) * longint'(hi[a]);
        end
      end
      if (d_pos < 0) outside = 1'b1;
      if (d_neg < 0) crossing = 1'b1;
    end
    if (outside) return VERDICT_OUTSIDE;
    if (crossing) return VERDICT_INTERSECT;
    return VERDICT_INSIDE;
  endfunction

  function automatic box_t random_box();
    return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Box centered around the slab region, now and then inverted on one axis.
  function automatic box_t near_frustum_box();
    int c[3];
    int h[3];
    int t;
    int a;
    for (int k = 0; k < 3; k++) begin
      c[k] = int'($urandom_range(40000)) - 20000;
      h[k] = ($urandom_range(3) == 0) ? int'($urandom_range(8000)) : int'($urandom_range(1500));
    end
    if ($urandom_range(19) == 0) begin
      a    = $urandom_range(2);
      t    = h[a];
      h[a] = -t;
    end
    return mk_box(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2]);
  endfunction

  function automatic plane_t axis_plane(int axis, bit flip, int off);
    int c[3];
    int mag;
    for (int k = 0; k < 3; k++) c[k] = int'($urandom_range(4096)) - 2048;
    mag     = $urandom_range(8192, 16384);
    c[axis] = flip ? -mag : mag;
    return mk_plane(c[0], c[1], c[2], off);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Write one register and track it in the shadow copy; indexes past the planes are dropped.
  task automatic write_plane_reg(logic [CFG_IDX_W-1:0] idx, plane_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx < PLANE_COUNT) plane_shadow[idx] = val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_plane_set(plane_set_t kind);
    plane_t val;
    int     off;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      case (kind)
        SET_SLAB: begin
          off = ($urandom_range(9) == 0) ? -int'($urandom_range(4000))
                                         : int'($urandom_range(20000));
          val = axis_plane(slab_axis[i], slab_flip[i], off);
        end
        SET_RANDOM:   val = {$urandom, $urandom};
        SET_MOST_NEG: val = {4{16'h8000}};
        SET_MOST_POS: val = {4{16'h7fff}};
        SET_ALL_ONES: val = {4{16'hffff}};
        default:      val = '0;
      endcase
      write_plane_reg(CFG_IDX_W'(i), val);
    end
    settings_used++;
  endtask

  // Hold until every queued box is accepted and every verdict is back, then let the pipe settle.
  task automatic drain_and_settle();
    do @(posedge clk);
    while (box_queue.size() != 0 || in_ch.valid || pending_verdicts.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Request driver: advance to the next box once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (box_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 17)) begin
        next_box = box_queue.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.box_min_x <= next_box.min_x;
        in_ch.box_min_y <= next_box.min_y;
        in_ch.box_min_z <= next_box.min_z;
        in_ch.box_max_x <= next_box.max_x;
        in_ch.box_max_y <= next_box.max_y;
        in_ch.box_max_z <= next_box.max_z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 17);
    end
  end

  // Predict a verdict for every accepted request.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      pending_verdicts.push_back(classify_box(mk_box(in_ch.box_min_x, in_ch.box_min_y,
                                                     in_ch.box_min_z, in_ch.box_max_x,
                                                     in_ch.box_max_y, in_ch.box_max_z)));
      boxes_accepted++;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no box pending", out_ch.verdict));
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (out_ch.verdict !== want_verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d (result %0d)",
                                    out_ch.verdict, want_verdict, verdicts_checked));
        if (want_verdict <= VERDICT_OUTSIDE) verdict_seen[want_verdict]++;
      end
      verdicts_checked++;
    end
  end

  // Watchdog on cycles with no traffic at all.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    box_t   b;
    plane_t slab[PLANE_COUNT];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.box_min_x = '0;
    in_ch.box_min_y = '0;
    in_ch.box_min_z = '0;
    in_ch.box_max_x = '0;
    in_ch.box_max_y = '0;
    in_ch.box_max_z = '0;
    out_ch.ready    = 1'b0;
    steady_flow     = 1'b0;
    mismatch_count  = 0;
    boxes_accepted  = 0;
    verdicts_checked = 0;
    verdict_seen    = '{0, 0, 0};
    settings_used   = 1;
    quiet_cycles    = 0;
    for (int i = 0; i < PLANE_COUNT; i++) plane_shadow[i] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Cleared planes after reset: every box is inside, even extreme and inverted ones.
    box_queue.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    box_queue.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    box_queue.push_back(mk_box(0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 8; k++) box_queue.push_back(random_box());
    drain_and_settle();

    // Fixed cube of half size 10.0; off-axis normal components are zero.
    slab[REG_PLANE_NEAR]   = mk_plane(0, 0, 16384, 2560);
    slab[REG_PLANE_FAR]    = mk_plane(0, 0, -16384, 2560);
    slab[REG_PLANE_LEFT]   = mk_plane(16384, 0, 0, 2560);
    slab[REG_PLANE_RIGHT]  = mk_plane(-16384, 0, 0, 2560);
    slab[REG_PLANE_TOP]    = mk_plane(0, -16384, 0, 2560);
    slab[REG_PLANE_BOTTOM] = mk_plane(0, 16384, 0, 2560);
    write_plane_reg(REG_PLANE_NEAR, slab[REG_PLANE_NEAR]);
    write_plane_reg(REG_PLANE_FAR, slab[REG_PLANE_FAR]);
    write_plane_reg(REG_PLANE_LEFT, slab[REG_PLANE_LEFT]);
    write_plane_reg(REG_PLANE_RIGHT, slab[REG_PLANE_RIGHT]);
    write_plane_reg(REG_PLANE_TOP, slab[REG_PLANE_TOP]);
    write_plane_reg(REG_PLANE_BOTTOM, slab[REG_PLANE_BOTTOM]);
    settings_used++;
    box_queue.push_back(mk_box(-256, -256, -256, 256, 256, 256));
    box_queue.push_back(mk_box(-5120, -256, -256, 0, 256, 256));
    box_queue.push_back(mk_box(5120, 0, 0, 6400, 256, 256));
    box_queue.push_back(mk_box(0, 0, -6400, 256, 256, -5120));
    box_queue.push_back(mk_box(0, 3000, 0, 256, 4000, 256));
    // corner exactly on a plane: zero distance is not below zero
    box_queue.push_back(mk_box(2560, 2560, 2560, 2560, 2560, 2560));
    box_queue.push_back(mk_box(256, 256, 256, -256, -256, -256));
    box_queue.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    box_queue.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
    drain_and_settle();

    // Writes past the last plane must leave the cube in place.
    write_plane_reg(REG_SPARE_6, '0);
    write_plane_reg(REG_SPARE_7, {4{16'hffff}});
    box_queue.push_back(mk_box(5120, 0, 0, 6400, 256, 256));
    box_queue.push_back(mk_box(-256, -256, -256, 256, 256, 256));
    drain_and_settle();

    // Most negative fields everywhere against extreme boxes.
    load_plane_set(SET_MOST_NEG);
    box_queue.push_back(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    box_queue.push_back(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    drain_and_settle();

    // Random part: one plane setting per phase, mostly well-formed boxes around slabs.
    foreach (schedule[p]) begin
      load_plane_set(schedule[p]);
      steady_flow = (p == 5);
      for (int k = 0; k < PHASE_BOXES; k++) begin
        if (schedule[p] == SET_SLAB)
          b = ($urandom_range(99) < 80) ? near_frustum_box() : random_box();
        else
          b = ($urandom_range(1) == 0) ? near_frustum_box() : random_box();
        box_queue.push_back(b);
      end
      drain_and_settle();
      steady_flow = 1'b0;
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

    $display("Covered %0d boxes over %0d plane settings, %0d verdicts checked",
             boxes_accepted, settings_used, verdicts_checked);
    $display("Predicted inside %0d, intersecting %0d, outside %0d; mismatches %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
